// ----- rtl/ccv_pkg.sv -----
// Shared types, constants and helpers for the 2-D convolution unit.
package ccv_pkg;

  localparam int KSIZE           = 3;
  localparam int MAX_WIDTH       = 1024;
  localparam int COEFF_FRAC_BITS = 12;

  localparam int CEN    = KSIZE / 2;
  localparam int TAPS   = KSIZE * KSIZE;
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + COEF_W;
  localparam int SUM_W  = PROD_W + $clog2(TAPS + 1);
  localparam int Q_W    = SUM_W - COEFF_FRAC_BITS;

  localparam int CFG_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int ROW_W     = FH_W;
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int COL_W     = $clog2(MAX_WIDTH);

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [Q_W-1:0]    q_t;

  localparam sum_t ROUND_BIAS = sum_t'((64'd1 << COEFF_FRAC_BITS) - 64'd1);
  localparam q_t   Q_MAX      = q_t'(127);
  localparam q_t   Q_MIN      = q_t'(-128);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEFFS_FIRST_FOUR  = 3'd0,
    REG_COEFFS_SECOND_FOUR = 3'd1,
    REG_COEFF_LAST         = 3'd2,
    REG_FRAME_WIDTH        = 3'd3,
    REG_FRAME_HEIGHT       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic op;
    pix_t pixel_value;
  } pix_req_t;

  typedef struct packed {
    pix_t out_value;
    logic out_clipped;
    logic out_last;
  } res_req_t;

  // Per-item side info that rides along the line buffer chain.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
    logic [COL_W-1:0] col;
  } tag_t;

  // rows[i] holds the pixel (KSIZE-1-i) lines behind the newest one once
  // the bus has passed all line cells.
  typedef struct packed {
    logic                   valid;
    tag_t                   tag;
    pix_t [KSIZE-1:0]       rows;
  } line_bus_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  function automatic coef_t coeff_at(input logic [CFG_W-1:0] first_four,
                                     input logic [CFG_W-1:0] second_four,
                                     input logic [COEF_W-1:0] last_one,
                                     input int k);
    coef_t c;
    if (k < 4) begin
      c = coef_t'(first_four[16*k +: 16]);
    end else if (k < 8) begin
      c = coef_t'(second_four[16*(k-4) +: 16]);
    end else begin
      c = coef_t'(last_one);
    end
    return c;
  endfunction

  function automatic logic [WID_W-1:0] clamp_width(input logic [FW_W-1:0] fw);
    logic [WID_W-1:0] w;
    if (fw == '0) begin
      w = WID_W'(1);
    end else if (int'(fw) > MAX_WIDTH) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(fw);
    end
    return w;
  endfunction

  function automatic logic [FH_W-1:0] clamp_height(input logic [FH_W-1:0] fh);
    return (fh == '0) ? FH_W'(1) : fh;
  endfunction

endpackage

// ----- rtl/ccv_line.sv -----
// Line buffer cell: one raster line of delay, one pipeline stage.
module ccv_line (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  ccv_pkg::line_bus_t  bus_in,
  output ccv_pkg::line_bus_t  bus_out
);

  ccv_pkg::pix_t mem [ccv_pkg::MAX_WIDTH];
  ccv_pkg::pix_t rd;
  logic          valid;
  ccv_pkg::tag_t tag;
  ccv_pkg::pix_t [ccv_pkg::KSIZE-1:1] rows_d;

  // read-first: the old entry of this column is the pixel one line back
  always_ff @(posedge clk) begin
    if (adv && bus_in.valid) begin
      rd                    <= mem[bus_in.tag.col];
      mem[bus_in.tag.col]   <= bus_in.rows[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && bus_in.valid) begin
      tag <= bus_in.tag;
      for (int i = 1; i < ccv_pkg::KSIZE; i++) begin
        rows_d[i] <= bus_in.rows[i-1];
      end
    end
  end

  always_comb begin
    bus_out.valid = valid;
    bus_out.tag   = tag;
    bus_out.rows  = {rows_d, rd};
  end

endmodule

// ----- rtl/ccv_tap.sv -----
// Window tap cell: holds one neighbour pixel and its weighted product.
module ccv_tap (
  input  logic            clk,
  input  logic            shift,
  input  ccv_pkg::pix_t   val_in,
  output ccv_pkg::pix_t   val,
  input  logic            mul_en,
  input  logic            keep,
  input  ccv_pkg::coef_t  coef,
  output ccv_pkg::prod_t  prod
);

  always_ff @(posedge clk) begin
    if (shift) begin
      val <= val_in;
    end
  end

  // out-of-frame neighbours weigh zero
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= keep ? ccv_pkg::prod_t'(val) * ccv_pkg::prod_t'(coef) : '0;
    end
  end

endmodule

// ----- rtl/ccv_acc.sv -----
// Adder tree plus truncate-toward-zero and 8-bit saturation.
module ccv_acc (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  ccv_pkg::ctl_t                              in_ctl,
  input  ccv_pkg::prod_t [ccv_pkg::TAPS-1:0]         prods,
  output ccv_pkg::ctl_t                              res_ctl,
  output ccv_pkg::res_req_t                          res_data
);

  ccv_pkg::sum_t rsum      [ccv_pkg::KSIZE];
  ccv_pkg::sum_t rsum_next [ccv_pkg::KSIZE];
  ccv_pkg::sum_t total;
  ccv_pkg::sum_t total_next;
  ccv_pkg::sum_t biased;
  ccv_pkg::q_t   q;
  ccv_pkg::ctl_t a_ctl;
  ccv_pkg::ctl_t b_ctl;

  always_comb begin
    for (int m = 0; m < ccv_pkg::KSIZE; m++) begin
      rsum_next[m] = '0;
      for (int k = 0; k < ccv_pkg::KSIZE; k++) begin
        rsum_next[m] = rsum_next[m] + ccv_pkg::sum_t'(prods[m*ccv_pkg::KSIZE + k]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int m = 0; m < ccv_pkg::KSIZE; m++) begin
      total_next = total_next + rsum[m];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
    end else if (adv) begin
      a_ctl <= in_ctl;
      b_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsum  <= rsum_next;
      total <= total_next;
    end
  end

  // negative sums get a bias so the arithmetic shift rounds toward zero
  always_comb begin
    biased = total + (total[ccv_pkg::SUM_W-1] ? ccv_pkg::ROUND_BIAS : '0);
    q      = ccv_pkg::q_t'(biased[ccv_pkg::SUM_W-1:ccv_pkg::COEFF_FRAC_BITS]);
    res_data.out_last = b_ctl.last;
    if (q > ccv_pkg::Q_MAX) begin
      res_data.out_value   = ccv_pkg::pix_t'(ccv_pkg::Q_MAX);
      res_data.out_clipped = 1'b1;
    end else if (q < ccv_pkg::Q_MIN) begin
      res_data.out_value   = ccv_pkg::pix_t'(ccv_pkg::Q_MIN);
      res_data.out_clipped = 1'b1;
    end else begin
      res_data.out_value   = ccv_pkg::pix_t'(q);
      res_data.out_clipped = 1'b0;
    end
  end

  assign res_ctl = b_ctl;

endmodule

// ----- rtl/image_convolution_2d_unit.sv -----
// Top level of the zero-padded KSIZE x KSIZE raster convolution unit.
// Throughput: one request per clock, sustained, whenever the result side keeps up.
// A result follows its request (width*KSIZE/2 + KSIZE/2) requests later in stream
//   order; from the edge that takes that later request it passes the line cells,
//   taps, products, two adds and the output register.
// Reset (rst, synchronous): pipeline, counters and output buffer empty, registers at
//   defaults; the line memories are not cleared, only pixels of the current frame are used.
module image_convolution_2d_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  ccv_pkg::pix_req_t                  pix_req,
  output logic                               res_valid,
  input  logic                               res_stall,
  output ccv_pkg::res_req_t                  res_req,
  input  logic                               cfg_we,
  input  logic [ccv_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [ccv_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int K = ccv_pkg::KSIZE;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ccv_pkg::CFG_W-1:0]  coeffs_first_four;
  logic [ccv_pkg::CFG_W-1:0]  coeffs_second_four;
  logic [ccv_pkg::COEF_W-1:0] coeff_last;
  logic [ccv_pkg::FW_W-1:0]   frame_width;
  logic [ccv_pkg::FH_W-1:0]   frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs_first_four  <= '0;
      coeffs_second_four <= ccv_pkg::CFG_W'(4096);
      coeff_last         <= '0;
      frame_width        <= ccv_pkg::FW_W'(640);
      frame_height       <= ccv_pkg::FH_W'(480);
    end else if (cfg_we) begin
      unique case (ccv_pkg::reg_idx_t'(cfg_index))
        ccv_pkg::REG_COEFFS_FIRST_FOUR:  coeffs_first_four  <= cfg_wdata;
        ccv_pkg::REG_COEFFS_SECOND_FOUR: coeffs_second_four <= cfg_wdata;
        ccv_pkg::REG_COEFF_LAST:         coeff_last   <= cfg_wdata[ccv_pkg::COEF_W-1:0];
        ccv_pkg::REG_FRAME_WIDTH:        frame_width  <= cfg_wdata[ccv_pkg::FW_W-1:0];
        ccv_pkg::REG_FRAME_HEIGHT:       frame_height <= cfg_wdata[ccv_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient k goes with the neighbour mirrored through the centre
  // (true convolution), so tap row m, cell k uses index (K-1-m)*K + k.
  ccv_pkg::coef_t coefs [ccv_pkg::TAPS];
  for (genvar t = 0; t < ccv_pkg::TAPS; t++) begin : g_coef
    assign coefs[t] = ccv_pkg::coeff_at(coeffs_first_four, coeffs_second_four,
                                        coeff_last, t);
  end

  // ---------------------------------------------------------------------------
  // Global advance: the whole pipeline moves unless the skid slot is full.
  // ---------------------------------------------------------------------------
  logic adv;
  logic accept;
  logic skid_valid;

  assign adv       = !skid_valid;
  assign pix_stall = skid_valid;
  assign accept    = pix_valid && adv;

  // ---------------------------------------------------------------------------
  // Frame tracking at the entry
  // ---------------------------------------------------------------------------
  logic                       busy;
  logic [ccv_pkg::WID_W-1:0]  cur_w;
  logic [ccv_pkg::FH_W-1:0]   cur_h;
  logic [ccv_pkg::COL_W-1:0]  in_col;
  logic [ccv_pkg::FH_W-1:0]   in_row;
  logic [ccv_pkg::COL_W-1:0]  out_col;
  logic [ccv_pkg::ROW_W-1:0]  out_row;

  logic [ccv_pkg::WID_W-1:0]  eff_w;
  logic [ccv_pkg::FH_W-1:0]   eff_h;
  logic                       item;
  logic                       emit_now;
  logic                       last_now;
  logic                       in_wrap;
  logic                       out_wrap;
  logic [K-1:0]               row_ok;
  logic [K-1:0]               col_ok;

  // geometry is sampled by the first request of a frame
  assign eff_w = busy ? cur_w : ccv_pkg::clamp_width(frame_width);
  assign eff_h = busy ? cur_h : ccv_pkg::clamp_height(frame_height);

  // a drain request with no frame open is dropped
  assign item = accept && (busy || !pix_req.op);

  assign emit_now = (in_row > ccv_pkg::FH_W'(ccv_pkg::CEN)) ||
                    ((in_row == ccv_pkg::FH_W'(ccv_pkg::CEN)) &&
                     (in_col >= ccv_pkg::COL_W'(ccv_pkg::CEN)));
  assign in_wrap  = ({1'b0, in_col} == ccv_pkg::WID_W'(eff_w - 1'b1));
  assign out_wrap = ({1'b0, out_col} == ccv_pkg::WID_W'(eff_w - 1'b1));
  assign last_now = emit_now && out_wrap &&
                    (out_row == ccv_pkg::FH_W'(eff_h - 1'b1));

  // Which window rows and columns of the output pixel lie inside the frame.
  always_comb begin
    for (int m = 0; m < K; m++) begin
      if (m < ccv_pkg::CEN) begin
        row_ok[m] = (out_row >= ccv_pkg::ROW_W'(ccv_pkg::CEN - m));
        col_ok[m] = (out_col >= ccv_pkg::COL_W'(ccv_pkg::CEN - m));
      end else begin
        row_ok[m] = ((out_row + ccv_pkg::FH_W'(m - ccv_pkg::CEN)) < eff_h);
        col_ok[m] = (({1'b0, out_col} + ccv_pkg::WID_W'(m - ccv_pkg::CEN)) < eff_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cur_w   <= ccv_pkg::WID_W'(1);
      cur_h   <= ccv_pkg::FH_W'(1);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (item) begin
      if (!busy) begin
        cur_w <= eff_w;
        cur_h <= eff_h;
      end
      if (last_now) begin
        // frame complete: next request opens a new one
        busy    <= 1'b0;
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        busy <= 1'b1;
        if (in_wrap) begin
          in_col <= '0;
          // only the first rows matter for the output start, so stop counting
          if (in_row <= ccv_pkg::FH_W'(ccv_pkg::CEN)) begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (emit_now) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer chain: each cell adds one line of delay and one stage.
  // ---------------------------------------------------------------------------
  ccv_pkg::line_bus_t bus [K];

  always_comb begin
    bus[0]            = '0;
    bus[0].valid      = item;
    bus[0].tag.emit   = emit_now;
    bus[0].tag.last   = last_now;
    bus[0].tag.row_ok = row_ok;
    bus[0].tag.col_ok = col_ok;
    bus[0].tag.col    = in_col;
    // drain requests enter the history as zero
    bus[0].rows[0]    = pix_req.op ? '0 : pix_req.pixel_value;
  end

  for (genvar j = 1; j < K; j++) begin : g_line
    ccv_line u_line (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .bus_in  (bus[j-1]),
      .bus_out (bus[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Window taps: row m shifts in the pixel of line delay (K-1-m); tap k of a
  // row holds the pixel k positions back.
  // ---------------------------------------------------------------------------
  logic                                 shift;
  logic                                 wvalid;
  ccv_pkg::tag_t                        wtag;
  ccv_pkg::pix_t                        tap_val [K][K];
  ccv_pkg::prod_t [ccv_pkg::TAPS-1:0]   prods;
  ccv_pkg::ctl_t                        pctl;

  assign shift = adv && bus[K-1].valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
      pctl   <= '0;
    end else if (adv) begin
      wvalid     <= bus[K-1].valid;
      pctl.valid <= wvalid && wtag.emit;
      pctl.last  <= wtag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      wtag <= bus[K-1].tag;
    end
  end

  for (genvar m = 0; m < K; m++) begin : g_row
    for (genvar k = 0; k < K; k++) begin : g_tap
      ccv_pkg::pix_t feed;
      if (k == 0) begin : g_head
        assign feed = bus[K-1].rows[m];
      end else begin : g_body
        assign feed = tap_val[m][k-1];
      end
      ccv_tap u_tap (
        .clk    (clk),
        .shift  (shift),
        .val_in (feed),
        .val    (tap_val[m][k]),
        .mul_en (adv && wvalid),
        .keep   (wtag.row_ok[m] && wtag.col_ok[K-1-k]),
        .coef   (coefs[(K-1-m)*K + k]),
        .prod   (prods[m*K + k])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Sum, round, saturate
  // ---------------------------------------------------------------------------
  ccv_pkg::ctl_t     acc_ctl;
  ccv_pkg::res_req_t acc_data;

  ccv_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_ctl   (pctl),
    .prods    (prods),
    .res_ctl  (acc_ctl),
    .res_data (acc_data)
  );

  // ---------------------------------------------------------------------------
  // Output register with skid slot: a result arriving while the output is
  // held parks in the skid slot, which then freezes the pipeline.
  // ---------------------------------------------------------------------------
  logic              out_valid;
  ccv_pkg::res_req_t out_data;
  ccv_pkg::res_req_t skid_data;
  logic              push;
  logic              pop;

  assign push = adv && acc_ctl.valid;
  assign pop  = out_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= acc_data;
      end else begin
        out_data <= acc_data;
      end
    end
  end

  assign res_valid = out_valid;
  assign res_req   = out_data;

endmodule
